>>> hdl/assert_macros.svh
// Assertion macros shared by the CRC engine RTL.
// No dependencies. Files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is held.
`define PCE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define PCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define PCE_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define PCE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/pce_pkg.sv
// Package of the CRC engine: register codes, reset values, shared types and
// the CRC arithmetic functions. No dependencies.
package pce_pkg;

    // Widest CRC the engine supports.
    localparam int unsigned MAX_WIDTH       = 32;
    // Default depth of the queue between front and back.
    localparam int unsigned PCE_QUEUE_DEPTH = 2;
    // Configuration address width: six registers at byte offsets 0..20.
    localparam int unsigned CFG_AW          = 5;

    // Register indexes.
    localparam logic [2:0] REG_CRC_WIDTH      = 3'd0;
    localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
    localparam logic [2:0] REG_INITIAL_VALUE  = 3'd2;
    localparam logic [2:0] REG_REFLECT_INPUT  = 3'd3;
    localparam logic [2:0] REG_REFLECT_OUTPUT = 3'd4;
    localparam logic [2:0] REG_FINAL_XOR      = 3'd5;

    // Width limits and reset values.
    localparam logic [5:0]  MIN_CRC_WIDTH     = 6'd8;
    localparam logic [5:0]  TOP_CRC_WIDTH     = 6'(MAX_WIDTH);
    localparam logic [31:0] RST_POLYNOMIAL    = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INITIAL_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_FINAL_XOR     = 32'hFFFF_FFFF;

    // Active configuration.
    typedef struct packed {
        logic [5:0]  crc_width;
        logic [31:0] polynomial;
        logic [31:0] initial_value;
        logic        reflect_input;
        logic        reflect_output;
        logic [31:0] final_xor;
    } t_cfg;

    // Classified item as it travels from front to back.
    typedef struct packed {
        logic        load;
        logic [31:0] load_value;
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic        last_item;
    } t_q_entry;

    // Number of unused bits above a CRC of width w.
    function automatic logic [5:0] pce_pad(input logic [5:0] w);
        return 6'd32 - w;
    endfunction

    function automatic logic [31:0] pce_mask(input logic [5:0] w);
        return 32'hFFFF_FFFF >> pce_pad(w);
    endfunction

    function automatic logic [7:0] pce_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

    // Reverse the low w bits of v; bits above w drop out.
    function automatic logic [31:0] pce_reflect(input logic [31:0] v, input logic [5:0] w);
        logic [31:0] r;
        for (int k = 0; k < 32; k++) begin
            r[k] = v[31-k];
        end
        return r >> pce_pad(w);
    endfunction

    // Finished CRC from the raw register.
    function automatic logic [31:0] pce_finish(input logic [31:0] v, input t_cfg cfg);
        logic [31:0] r;
        r = cfg.reflect_output ? pce_reflect(v, cfg.crc_width) : v;
        return (r ^ cfg.final_xor) & pce_mask(cfg.crc_width);
    endfunction

    // Raw register value from a finished CRC.
    function automatic logic [31:0] pce_unfinish(input logic [31:0] v, input t_cfg cfg);
        logic [31:0] r;
        r = v ^ cfg.final_xor;
        if (cfg.reflect_output) begin
            r = pce_reflect(r, cfg.crc_width);
        end
        return r & pce_mask(cfg.crc_width);
    endfunction

    // One byte through eight MSB-first steps. The register is moved to the
    // top of a 32-bit word so the feedback tap is always bit 31.
    function automatic logic [31:0] pce_absorb(input logic [31:0] crc, input logic [7:0] b,
                                               input t_cfg cfg);
        logic [5:0]  pad;
        logic [31:0] a;
        logic [31:0] p;
        pad = pce_pad(cfg.crc_width);
        a = crc << pad;
        p = cfg.polynomial << pad;
        a[31:24] = a[31:24] ^ b;
        for (int k = 0; k < 8; k++) begin
            a = a[31] ? ((a << 1) ^ p) : (a << 1);
        end
        return a >> pad;
    endfunction

endpackage

>>> hdl/pce_if.sv
// Stream channels of the CRC engine: message bytes in, finished CRCs out.
// No dependencies.
interface pce_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        first_item;
    logic        resume;
    logic [31:0] resume_value;
    logic        last_item;

    modport source(output valid, data_byte, byte_valid, first_item, resume, resume_value,
                   last_item, input ready);
    modport sink(input valid, data_byte, byte_valid, first_item, resume, resume_value,
                 last_item, output ready);
endinterface

interface pce_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_out;

    modport source(output valid, crc_out, input ready);
    modport sink(input valid, crc_out, output ready);
endinterface

>>> hdl/pce_regs.sv
// Configuration registers of the CRC engine behind an APB-style port.
// Depends on pce_pkg.
module pce_regs
    import pce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [5:0] new_width;

    assign wr_en     = i_psel && i_penable && i_pwrite;
    assign reg_idx   = i_paddr[CFG_AW-1:2];
    assign new_width = i_pwdata[5:0];

    // Register writes; a width outside the supported range is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_width      <= TOP_CRC_WIDTH;
            r_cfg.polynomial     <= RST_POLYNOMIAL;
            r_cfg.initial_value  <= RST_INITIAL_VALUE;
            r_cfg.reflect_input  <= 1'b1;
            r_cfg.reflect_output <= 1'b1;
            r_cfg.final_xor      <= RST_FINAL_XOR;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CRC_WIDTH: begin
                    if (new_width >= MIN_CRC_WIDTH && new_width <= TOP_CRC_WIDTH) begin
                        r_cfg.crc_width <= new_width;
                    end
                end
                REG_POLYNOMIAL:     r_cfg.polynomial     <= i_pwdata;
                REG_INITIAL_VALUE:  r_cfg.initial_value  <= i_pwdata;
                REG_REFLECT_INPUT:  r_cfg.reflect_input  <= i_pwdata[0];
                REG_REFLECT_OUTPUT: r_cfg.reflect_output <= i_pwdata[0];
                REG_FINAL_XOR:      r_cfg.final_xor      <= i_pwdata;
                default: begin
                end
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_idx)
            REG_CRC_WIDTH:      o_prdata = {26'd0, r_cfg.crc_width};
            REG_POLYNOMIAL:     o_prdata = r_cfg.polynomial;
            REG_INITIAL_VALUE:  o_prdata = r_cfg.initial_value;
            REG_REFLECT_INPUT:  o_prdata = {31'd0, r_cfg.reflect_input};
            REG_REFLECT_OUTPUT: o_prdata = {31'd0, r_cfg.reflect_output};
            REG_FINAL_XOR:      o_prdata = r_cfg.final_xor;
            default:            o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/pce_front.sv
// Front of the CRC engine: takes message items and turns each into a queue
// entry with the load value and the input byte already prepared.
// Depends on pce_pkg and pce_if.
module pce_front
    import pce_pkg::*;
(
    pce_in_if.sink   i_in,
    input  t_cfg     i_cfg,
    input  logic     i_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    // An item is taken whenever the queue has room.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Start value: the configured seed, or a finished CRC turned back into
    // register form when a message is resumed.
    always_comb begin
        o_entry.load       = i_in.first_item;
        o_entry.load_value = i_in.resume
                           ? pce_unfinish(i_in.resume_value, i_cfg)
                           : (i_cfg.initial_value & pce_mask(i_cfg.crc_width));
        o_entry.byte_valid = i_in.byte_valid;
        o_entry.data_byte  = i_cfg.reflect_input ? pce_rev8(i_in.data_byte) : i_in.data_byte;
        o_entry.last_item  = i_in.last_item;
    end

endmodule

>>> hdl/pce_queue.sv
// Short queue between the front and the back of the CRC engine.
// Depends on pce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pce_queue
    import pce_pkg::*;
#(
    parameter int unsigned DEPTH = PCE_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_full,
    output logic     o_valid,
    output t_q_entry o_entry,
    input  logic     i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_q_entry           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `PCE_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue fill count above depth")
    `PCE_ASSERT_RST(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not rise on a lone push")
    `PCE_ASSERT_RST(a_count_down, i_clk, i_rst_n, (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1), "queue count did not fall on a lone pop")

endmodule

>>> hdl/pce_back.sv
// Back of the CRC engine: holds the CRC register, absorbs at most one byte
// per entry and delivers finished CRCs through an output register.
// Depends on pce_pkg and pce_if.
module pce_back
    import pce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_q_entry i_entry,
    output logic     o_pop,
    pce_out_if.source o_out
);

    logic [31:0] r_crc;
    logic [31:0] r_crc_out;
    logic        r_out_valid;
    logic [31:0] n_crc;
    logic        n_out_valid;
    logic [31:0] base;
    logic        out_free;

    // A result slot is free when empty or being taken this cycle; only
    // entries that end a message wait for it.
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_valid && (!i_entry.last_item || out_free);

    // Load first, then the byte.
    always_comb begin
        base  = i_entry.load ? i_entry.load_value : r_crc;
        n_crc = i_entry.byte_valid ? pce_absorb(base, i_entry.data_byte, i_cfg) : base;
    end

    // Output valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && i_entry.last_item) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_crc <= n_crc;
            end
        end
    end

    // Finished CRC capture.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last_item) begin
            r_crc_out <= pce_finish(n_crc, i_cfg);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.crc_out = r_crc_out;

endmodule

>>> hdl/parameterized_crc_engine_top.sv
// Top level of the configurable CRC engine (widths 8 to 32 bits).
// Depends on pce_pkg, pce_if, pce_regs, pce_front, pce_queue and pce_back.
//
//   Port      Role     Carries
//   i_in      sink     message byte, byte flag, first/last flags, resume value
//   o_out     source   finished CRC
//   APB       slave    six configuration registers at byte offsets 0..20
//
// One message item per cycle is sustained while nothing stalls; the absorb of
// eight shift steps in the back unit sets that cycle. Each taken transaction is
// queued, then absorbed by the back, which registers a message's finished CRC.
// Reset clears the queue, the CRC register, the result flag and restores the
// configuration defaults; there is no clearing pass.
// The input stalls only when the queue is full; a held result blocks only
// entries that end a message.
module parameterized_crc_engine_top
    import pce_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = PCE_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pce_in_if.sink            i_in,
    pce_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg     cfg;
    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_q_entry q_wr_entry;
    t_q_entry q_rd_entry;

    // The register port never waits.
    assign pready = 1'b1;

    pce_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    pce_front u_front (
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_wr_entry)
    );

    pce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_rd_entry),
        .i_pop   (q_pop)
    );

    pce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .i_entry (q_rd_entry),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

>>> verif/tb_parameterized_crc_engine_top.sv
// Self-checking testbench for the configurable CRC engine top level.
// Depends on pce_pkg, pce_in_if, pce_out_if and parameterized_crc_engine_top.
// A built-in predictor mirrors the CRC arithmetic and checks every finished CRC in order.
module tb_parameterized_crc_engine_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pce_pkg::*;

    // Register indexes past the end of the register map; writes there do nothing.
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    // One message transaction as the sender presents it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        first_item;
        logic        resume;
        logic [31:0] resume_value;
        logic        last_item;
    } t_crc_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pce_in_if  in_bus();
    pce_out_if out_bus();

    parameterized_crc_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration and of the CRC register.
    logic [5:0]  cur_width;
    logic [31:0] cur_poly;
    logic [31:0] cur_init;
    logic        cur_refin;
    logic        cur_refout;
    logic [31:0] cur_fxor;
    logic [31:0] crc_state;

    t_crc_item   msg_items[$];
    logic [31:0] crc_expect[$];

    int err_count = 0;
    int in_gap    = 0;
    int out_gap   = 0;
    int hold_left = 0;
    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;
    bit in_fire   = 1'b0;
    bit out_fire  = 1'b0;

    // Clock with a 12 ns period.
    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic note_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%08h, expected 0x%08h",
                 $time, what, got, want);
        err_count++;
    endtask

    function automatic logic [31:0] width_bits(input logic [5:0] w);
        return (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    endfunction

    // Reverses the low w bits; bits above w are dropped.
    function automatic logic [31:0] mirror_bits(input logic [31:0] v, input int w);
        logic [31:0] r;
        r = '0;
        for (int k = 0; k < w; k++) begin
            if (v[k]) r[w-1-k] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] finished_from_raw(input logic [31:0] v);
        if (cur_refout) v = mirror_bits(v, cur_width);
        return (v ^ cur_fxor) & width_bits(cur_width);
    endfunction

    function automatic logic [31:0] raw_from_finished(input logic [31:0] v);
        v = v ^ cur_fxor;
        if (cur_refout) v = mirror_bits(v, cur_width);
        return v & width_bits(cur_width);
    endfunction

    // Feeds one byte into the register through eight MSB-first steps.
    function automatic logic [31:0] shift_in_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] m;
        logic [31:0] p;
        logic [7:0]  d;
        m = width_bits(cur_width);
        p = cur_poly & m;
        d = cur_refin ? 8'(mirror_bits({24'd0, b}, 8)) : b;
        crc = crc ^ ({24'd0, d} << (cur_width - 6'd8));
        for (int k = 0; k < 8; k++) begin
            if (crc[cur_width - 6'd1]) crc = (crc << 1) ^ p;
            else crc = crc << 1;
            crc = crc & m;
        end
        return crc;
    endfunction

    // Load first, then the byte, then the emission of the finished CRC.
    function automatic void crc_step(input t_crc_item it, output logic emit,
                                     output logic [31:0] value);
        if (it.first_item) begin
            crc_state = it.resume ? raw_from_finished(it.resume_value)
                                  : (cur_init & width_bits(cur_width));
        end
        if (it.byte_valid) crc_state = shift_in_byte(crc_state, it.data_byte);
        emit  = it.last_item;
        value = finished_from_raw(crc_state);
    endfunction

    // APB write: setup cycle, access cycle, then release.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CRC_WIDTH: begin
                if (value[5:0] >= MIN_CRC_WIDTH && value[5:0] <= TOP_CRC_WIDTH) begin
                    cur_width = value[5:0];
                end
            end
            REG_POLYNOMIAL:     cur_poly   = value;
            REG_INITIAL_VALUE:  cur_init   = value;
            REG_REFLECT_INPUT:  cur_refin  = value[0];
            REG_REFLECT_OUTPUT: cur_refout = value[0];
            REG_FINAL_XOR:      cur_fxor   = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_cfg(input logic [5:0] w, input logic [31:0] poly, input logic [31:0] init,
                           input logic ri, input logic ro, input logic [31:0] fx);
        cfg_write(REG_CRC_WIDTH, {26'd0, w});
        cfg_write(REG_POLYNOMIAL, poly);
        cfg_write(REG_INITIAL_VALUE, init);
        cfg_write(REG_REFLECT_INPUT, {31'd0, ri});
        cfg_write(REG_REFLECT_OUTPUT, {31'd0, ro});
        cfg_write(REG_FINAL_XOR, fx);
    endtask

    task automatic push_item(input logic [7:0] d, input logic v, input logic f, input logic r,
                             input logic [31:0] rv, input logic l);
        t_crc_item it;
        it.data_byte    = d;
        it.byte_valid   = v;
        it.first_item   = f;
        it.resume       = r;
        it.resume_value = rv;
        it.last_item    = l;
        msg_items.push_back(it);
    endtask

    // Mostly well-formed messages with random content, some loose noise items.
    task automatic run_random_phase(input int n_items);
        int          len;
        logic        res;
        logic [31:0] rv;
        while (msg_items.size() < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                push_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          $urandom, 1'($urandom));
            end else begin
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                res = ($urandom_range(0, 3) == 0);
                rv  = $urandom;
                if (len == 0) begin
                    push_item(8'($urandom), 1'b0, 1'b1, res, rv, 1'b1);
                end
                for (int k = 0; k < len; k++) begin
                    // Idle transactions inside a message carry ignored content.
                    if (k > 0 && $urandom_range(0, 5) == 0) begin
                        push_item(8'($urandom), 1'b0, 1'b0, 1'($urandom), $urandom, 1'b0);
                    end
                    push_item(8'($urandom), 1'b1, k == 0, (k == 0) ? res : 1'($urandom),
                              (k == 0) ? rv : $urandom, k == len - 1);
                end
            end
        end
    endtask

    // Waits until all work is done, then for the pipeline to empty.
    task automatic settle();
        while (msg_items.size() != 0 || crc_expect.size() != 0) @(posedge i_clk);
        repeat (PCE_QUEUE_DEPTH + 6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver hold-off counter.
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left--;
    end

    // Monitor: checks result transactions and predicts on accepted input transactions.
    always @(posedge i_clk) begin : monitor
        t_crc_item   it;
        logic        emit;
        logic [31:0] want;
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                out_fire = 1'b1;
                if (crc_expect.size() == 0) begin
                    note_error("unexpected crc_out", out_bus.crc_out, 32'd0);
                end else begin
                    want = crc_expect.pop_front();
                    if (out_bus.crc_out !== want) note_error("crc_out", out_bus.crc_out, want);
                end
                out_gap = out_burst ? 0 : $urandom_range(0, 8);
            end
            if (in_bus.valid && in_bus.ready) begin
                in_fire = 1'b1;
                it = msg_items.pop_front();
                crc_step(it, emit, want);
                if (emit) crc_expect.push_back(want);
                in_gap = in_burst ? 0 : $urandom_range(0, 8);
            end
        end
    end

    // Driver: presents input transactions and drives the result ready.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_bus.valid || in_fire) begin
                if (in_gap > 0) begin
                    in_bus.valid <= 1'b0;
                    in_gap--;
                end else if (msg_items.size() != 0) begin
                    in_bus.valid        <= 1'b1;
                    in_bus.data_byte    <= msg_items[0].data_byte;
                    in_bus.byte_valid   <= msg_items[0].byte_valid;
                    in_bus.first_item   <= msg_items[0].first_item;
                    in_bus.resume       <= msg_items[0].resume;
                    in_bus.resume_value <= msg_items[0].resume_value;
                    in_bus.last_item    <= msg_items[0].last_item;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_bus.ready <= 1'b0;
                out_gap--;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [5:0]  w;
        logic [31:0] poly;
        logic [31:0] init;
        logic [31:0] fx;
        logic [7:0]  check_str[9];

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_bus.valid        = 1'b0;
        in_bus.data_byte    = '0;
        in_bus.byte_valid   = 1'b0;
        in_bus.first_item   = 1'b0;
        in_bus.resume       = 1'b0;
        in_bus.resume_value = '0;
        in_bus.last_item    = 1'b0;
        out_bus.ready       = 1'b0;

        cur_width  = TOP_CRC_WIDTH;
        cur_poly   = RST_POLYNOMIAL;
        cur_init   = RST_INITIAL_VALUE;
        cur_refin  = 1'b1;
        cur_refout = 1'b1;
        cur_fxor   = RST_FINAL_XOR;
        crc_state  = '0;

        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed checks under the reset configuration.
        // Bytes with no start continue from the cleared register.
        push_item(8'h31, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
        // Resume without a start is ignored.
        push_item(8'h32, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
        push_item(8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1);
        // The standard check string.
        for (int k = 0; k < 9; k++) begin
            push_item(check_str[k], 1'b1, k == 0, 1'b0, 32'd0, k == 8);
        end
        // Empty message, and empty resumed message.
        push_item(8'hFF, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1);
        push_item(8'h00, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // Resumed single-byte message and byte extremes.
        push_item(8'hFF, 1'b1, 1'b1, 1'b1, 32'hCBF4_3926, 1'b1);
        push_item(8'h00, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
        // Message left open across the next configuration change.
        push_item(8'hA5, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0);
        settle();

        // Out-of-range widths are ignored; upper data bits of the width write are dropped.
        cfg_write(REG_CRC_WIDTH, 32'd0);
        cfg_write(REG_CRC_WIDTH, 32'd7);
        cfg_write(REG_CRC_WIDTH, 32'd33);
        cfg_write(REG_CRC_WIDTH, 32'hFFFF_FFFF);
        cfg_write(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        cfg_write(REG_UNMAPPED_HI, 32'h1234_5678);
        cfg_write(REG_CRC_WIDTH, 32'h0000_0048);
        cfg_write(REG_POLYNOMIAL, 32'hFFFF_FF07);
        cfg_write(REG_INITIAL_VALUE, 32'd0);
        cfg_write(REG_REFLECT_INPUT, 32'd0);
        cfg_write(REG_REFLECT_OUTPUT, 32'hFFFF_FFFE);
        cfg_write(REG_FINAL_XOR, 32'd0);
        // The open message continues at the narrower width.
        push_item(8'h5A, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        settle();

        // Random phases, the first two at the configuration extremes.
        for (int p = 0; p < 9; p++) begin
            if (p == 0) begin
                set_cfg(TOP_CRC_WIDTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
            end else if (p == 1) begin
                set_cfg(MIN_CRC_WIDTH, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0);
            end else begin
                case ($urandom_range(0, 4))
                    0: w = MIN_CRC_WIDTH;
                    1: w = TOP_CRC_WIDTH;
                    2: w = 6'd16;
                    default: w = 6'($urandom_range(8, 32));
                endcase
                poly = $urandom;
                init = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
                fx   = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
                set_cfg(w, poly, init, 1'($urandom), 1'($urandom), fx);
            end
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            run_random_phase(38);
            settle();
        end

        // Receiver stalls for a long stretch while short messages keep coming.
        set_cfg(6'd16, 32'h0000_1021, 32'h0000_FFFF, 1'b0, 1'b0, 32'd0);
        in_burst  = 1'b1;
        out_burst = 1'b0;
        hold_left = 200;
        for (int k = 0; k < 30; k++) begin
            push_item(8'($urandom), 1'b1, 1'b1, 1'($urandom), $urandom, 1'b1);
        end
        settle();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/pce_pkg.sv
hdl/pce_if.sv
hdl/pce_regs.sv
hdl/pce_front.sv
hdl/pce_queue.sv
hdl/pce_back.sv
hdl/parameterized_crc_engine_top.sv
verif/tb_parameterized_crc_engine_top.sv
